// ===== src/int8_softmax_core_macros.svh =====
// Assertion macros for the softmax core.
`ifndef INT8_SOFTMAX_CORE_MACROS_SVH
`define INT8_SOFTMAX_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define SMX_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("softmax assertion failed");
`define SMX_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("softmax assertion failed");
`else
`define SMX_ASSERT_IMPL(label, clk, rst, ante, cons)
`define SMX_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== src/smx_pkg.sv =====
// ----------------------------------------------------------------------------
// smx_pkg
// Shared constants, types and the 2^-x table of the softmax core.
// ----------------------------------------------------------------------------
package smx_pkg;
  localparam int MAX_LEN_DEF = 64;
  localparam logic [16:0] LOG2E_Q16 = 17'd94548;
  localparam logic [4:0] FIX_RESET = 5'sd4;

  // Queue entry from the front end: one logit and its end-of-vector flag.
  typedef struct packed {
    logic [7:0] logit;
    logic       last;
  } smx_item_t;

  function automatic logic [15:0] pow2_tab(input logic [4:0] i);
    logic [15:0] v;
    case (i)
      5'd0: v = 16'd32768;  5'd1: v = 16'd32066;  5'd2: v = 16'd31379;
      5'd3: v = 16'd30706;  5'd4: v = 16'd30048;  5'd5: v = 16'd29405;
      5'd6: v = 16'd28774;  5'd7: v = 16'd28158;  5'd8: v = 16'd27554;
      5'd9: v = 16'd26964;  5'd10: v = 16'd26386; 5'd11: v = 16'd25821;
      5'd12: v = 16'd25268; 5'd13: v = 16'd24726; 5'd14: v = 16'd24196;
      5'd15: v = 16'd23678; 5'd16: v = 16'd23170; 5'd17: v = 16'd22674;
      5'd18: v = 16'd22188; 5'd19: v = 16'd21713; 5'd20: v = 16'd21247;
      5'd21: v = 16'd20792; 5'd22: v = 16'd20347; 5'd23: v = 16'd19911;
      5'd24: v = 16'd19484; 5'd25: v = 16'd19067; 5'd26: v = 16'd18658;
      5'd27: v = 16'd18258; 5'd28: v = 16'd17866; 5'd29: v = 16'd17483;
      5'd30: v = 16'd17109; default: v = 16'd16742;
    endcase
    return v;
  endfunction
endpackage

// ===== src/int8_softmax_core.sv =====
// ----------------------------------------------------------------------------
// int8_softmax_core
// Loading pops logits from the FIFO until the last one; then an exp pass
// (RAM read, exp) and a normalization pass (RAM read, divider start, serial
// divider of 39 steps, output) per element. Output is one element at a time.
// Reset (synchronous) empties the FIFO, clears count, max and sum.
// ----------------------------------------------------------------------------
`include "int8_softmax_core_macros.svh"
module int8_softmax_core #(
  parameter int MAX_LEN = smx_pkg::MAX_LEN_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [4:0]  cfg_wdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // logit
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // element_index[5:0], probability[21:6], zeros
  output logic        m_axis_tlast
);
  logic [4:0]         fix_position;
  logic               q_valid, q_pop, busy;
  smx_pkg::smx_item_t q_item;
  logic [5:0]         idx;
  logic [15:0]        prob;

  always_ff @(posedge clk) begin
    if (rst) begin
      fix_position <= smx_pkg::FIX_RESET;
    end else if (cfg_we) begin
      fix_position <= cfg_wdata;
    end
  end

  smx_front u_front (
    .clk(clk), .rst(rst), .s_tvalid(s_axis_tvalid), .s_tready(s_axis_tready),
    .s_logit(s_axis_tdata), .s_last(s_axis_tlast),
    .q_valid(q_valid), .q_pop(q_pop), .q_item(q_item));

  smx_back #(.MAX_LEN(MAX_LEN)) u_back (
    .clk(clk), .rst(rst), .fix_position(fix_position),
    .q_valid(q_valid), .q_pop(q_pop), .q_item(q_item),
    .m_tvalid(m_axis_tvalid), .m_tready(m_axis_tready),
    .m_index(idx), .m_prob(prob), .m_last(m_axis_tlast), .busy(busy));

  assign m_axis_tdata = {2'b00, prob, idx};

  `SMX_ASSERT_IMPL(a_pop_valid, clk, rst, q_pop, q_valid)
  `SMX_ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  `SMX_ASSERT_IMPL(a_busy_out, clk, rst, m_axis_tvalid, busy)
endmodule

// ===== src/smx_ram.sv =====
// ----------------------------------------------------------------------------
// smx_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module smx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== src/smx_front.sv =====
// ----------------------------------------------------------------------------
// smx_front
// Input side: accepts logits and pushes them into a small FIFO.
// ----------------------------------------------------------------------------
module smx_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [7:0]         s_logit,
  input  logic               s_last,
  output logic               q_valid,
  input  logic               q_pop,
  output smx_pkg::smx_item_t q_item
);
  smx_pkg::smx_item_t fifo [4];
  logic [1:0] wptr;
  logic [1:0] rptr;
  logic [2:0] count;
  logic       push;

  assign s_tready = (count != 3'd4);
  assign push     = s_tvalid && s_tready;
  assign q_valid  = (count != 3'd0);
  assign q_item   = fifo[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wptr] <= '{logit: s_logit, last: s_last};
    end
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 2'd1;
      end
      if (q_pop) begin
        rptr <= rptr + 2'd1;
      end
      count <= count + {2'd0, push} - {2'd0, q_pop};
    end
  end
endmodule

// ===== src/smx_div.sv =====
// ----------------------------------------------------------------------------
// smx_div
// Restoring divider, one quotient bit per cycle, 39-bit dividend.
// ----------------------------------------------------------------------------
module smx_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [38:0] dividend,
  input  logic [22:0] divisor,
  output logic        done,
  output logic [38:0] quotient
);
  logic [23:0] rem;
  logic [38:0] quo;
  logic [22:0] dsr;
  logic [5:0]  cnt;
  logic        busy;
  logic [23:0] trial;

  assign trial    = {rem[22:0], quo[38]};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'd39;
        rem  <= '0;
        quo  <= dividend;
        dsr  <= divisor;
      end else if (busy) begin
        if (trial >= {1'b0, dsr}) begin
          rem <= trial - {1'b0, dsr};
          quo <= {quo[37:0], 1'b1};
        end else begin
          rem <= trial;
          quo <= {quo[37:0], 1'b0};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// ===== src/smx_back.sv =====
// ----------------------------------------------------------------------------
// smx_back
// Loads the vector, then runs the exponential and normalization passes.
// ----------------------------------------------------------------------------
module smx_back #(
  parameter int MAX_LEN = smx_pkg::MAX_LEN_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [4:0]         fix_position,
  input  logic               q_valid,
  output logic               q_pop,
  input  smx_pkg::smx_item_t q_item,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [5:0]         m_index,
  output logic [15:0]        m_prob,
  output logic               m_last,
  output logic               busy
);
  localparam int AW = $clog2(MAX_LEN);
  localparam int CW = $clog2(MAX_LEN + 1);
  localparam logic [2:0] ST_LOAD = 3'd0, ST_ERD = 3'd1, ST_EXP = 3'd2,
                         ST_NRD = 3'd3, ST_DIV = 3'd4, ST_OUT = 3'd5, ST_DWT = 3'd6;

  logic [2:0]       state;
  logic [CW-1:0]    count;
  logic [CW-1:0]    idx;
  logic signed [7:0] rmax;
  logic [22:0]      sum;
  logic [AW-1:0]    lraddr, eraddr;
  logic [7:0]       lrdata;
  logic [15:0]      erdata;
  logic             lwe, ewe;
  logic [15:0]      e_val;
  logic [7:0]       t;
  logic [24:0]      zm;
  logic [56:0]      z;
  logic signed [5:0] sh;
  logic             div_start, div_done;
  logic [38:0]      div_q;
  logic             room;

  assign room  = count < CW'(MAX_LEN);
  assign q_pop = (state == ST_LOAD) && q_valid;
  assign lwe   = q_pop && room;
  assign busy  = (state != ST_LOAD) || q_valid;

  smx_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_lram (
    .clk(clk), .we(lwe), .waddr(count[AW-1:0]), .wdata(q_item.logit),
    .raddr(lraddr), .rdata(lrdata));
  assign lraddr = idx[AW-1:0];

  // Exponential of the distance to the maximum.
  always_comb begin
    t  = 8'(rmax - $signed(lrdata));
    zm = {17'd0, t} * {8'd0, smx_pkg::LOG2E_Q16};
    sh = $signed({fix_position[4], fix_position}) - 6'sd7;
    if (sh >= 0) begin
      z = {32'd0, zm} << sh[3:0];
    end else begin
      z = {32'd0, zm} >> (-sh);
    end
    if (t == 8'd0) begin
      e_val = 16'd32768;
    end else if (z[56:20] != '0) begin
      e_val = 16'd0;
    end else begin
      e_val = smx_pkg::pow2_tab(z[15:11]) >> z[19:16];
    end
  end

  assign ewe    = (state == ST_EXP);
  assign eraddr = idx[AW-1:0];
  smx_ram #(.WIDTH(16), .DEPTH(MAX_LEN)) u_eram (
    .clk(clk), .we(ewe), .waddr(idx[AW-1:0]), .wdata(e_val),
    .raddr(eraddr), .rdata(erdata));

  assign div_start = (state == ST_DIV);
  smx_div u_div (
    .clk(clk), .rst(rst), .start(div_start),
    .dividend({7'd0, erdata, 16'd0} + {17'd0, sum[22:1]}),
    .divisor(sum), .done(div_done), .quotient(div_q));

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_LOAD;
      count    <= '0;
      idx      <= '0;
      rmax     <= -8'sd128;
      sum      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      case (state)
        ST_LOAD: begin
          if (q_pop) begin
            if (lwe) begin
              count <= count + CW'(1);
              if ($signed(q_item.logit) > rmax) begin
                rmax <= $signed(q_item.logit);
              end
            end
            if (q_item.last) begin
              idx   <= '0;
              sum   <= '0;
              state <= ST_ERD;
            end
          end
        end
        ST_ERD: state <= ST_EXP;
        ST_EXP: begin
          sum <= sum + {7'd0, e_val};
          if (idx + CW'(1) == count) begin
            idx   <= '0;
            state <= ST_NRD;
          end else begin
            idx   <= idx + CW'(1);
            state <= ST_ERD;
          end
        end
        ST_NRD: state <= ST_DIV;
        ST_DIV: state <= ST_DWT;
        ST_DWT: begin
          if (div_done) begin
            m_index  <= 6'(idx);
            m_prob   <= (div_q > 39'd65535) ? 16'hFFFF : div_q[15:0];
            m_last   <= (idx + CW'(1) == count);
            m_tvalid <= 1'b1;
            state    <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (m_tready) begin
            m_tvalid <= 1'b0;
            if (m_last) begin
              count <= '0;
              rmax  <= -8'sd128;
              sum   <= '0;
              state <= ST_LOAD;
            end else begin
              idx   <= idx + CW'(1);
              state <= ST_NRD;
            end
          end
        end
        default: state <= ST_LOAD;
      endcase
    end
  end
endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for int8_softmax_core. Logit vectors are streamed in
// with random gaps while the result side stalls at random. A behavioral
// predictor computes the Q0.16 probabilities of each vector, and every
// output transaction is checked against them in order.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [5:0]  idx;
    logic [15:0] prob;
    logic        last;
  } prob_t;

  typedef struct {
    logic signed [7:0] logit;
    bit                last;
    bit                known;
    logic [15:0]       known_prob;
  } row_t;

  localparam int VEC_MAX = 64;
  localparam int ITEM_TARGET = 460;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [4:0]  cfg_wdata = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // logit
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;        // element_index[5:0], probability[21:6], zeros
  logic        m_axis_tlast;

  // Directed vectors; the typed-in values hold for the reset scale of 4.
  row_t dir_rows [11] = '{
    '{8'sd5,   1'b1, 1'b1, 16'd65535},   // single element saturates
    '{-8'sd7,  1'b0, 1'b1, 16'd32768},   // two equal elements split evenly
    '{-8'sd7,  1'b1, 1'b1, 16'd32768},
    '{8'sd127, 1'b0, 1'b1, 16'd65535},   // widest spread
    '{8'h80,   1'b1, 1'b1, 16'd0},
    '{8'sd10,  1'b0, 1'b0, 16'd0},
    '{8'sd20,  1'b0, 1'b0, 16'd0},
    '{-8'sd30, 1'b0, 1'b0, 16'd0},
    '{8'sd0,   1'b1, 1'b0, 16'd0},
    '{8'h80,   1'b0, 1'b1, 16'd32768},   // two minimum logits
    '{8'h80,   1'b1, 1'b1, 16'd32768}
  };

  logic [4:0] cfg_vals [4] = '{5'd8, 5'b11000, 5'd15, 5'b10000};

  int unsigned pow2_q15 [32] = '{
    32768, 32066, 31379, 30706, 30048, 29405, 28774, 28158,
    27554, 26964, 26386, 25821, 25268, 24726, 24196, 23678,
    23170, 22674, 22188, 21713, 21247, 20792, 20347, 19911,
    19484, 19067, 18658, 18258, 17866, 17483, 17109, 16742
  };

  // Predictor state.
  int          m_fix = 4;
  int          m_logit [VEC_MAX];
  bit          kn_flag [VEC_MAX];
  logic [15:0] kn_prob [VEC_MAX];
  int          m_count = 0;
  int          m_rmax = -128;
  prob_t       exp_q [$];

  int errors = 0;
  int n_sent = 0;
  bit no_idle = 1'b0;

  int8_softmax_core uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("Verification failed");
    $finish;
  end

  function automatic int unsigned exp_of_distance(input int unsigned t);
    longint unsigned z;
    longint unsigned k;
    int s;
    z = t;
    z = z * 94548;
    s = m_fix - 7;
    if (s >= 0) begin
      z = z << s;
    end else begin
      z = z >> (-s);
    end
    k = z >> 16;
    if (k >= 16) begin
      return 0;
    end
    return pow2_q15[int'((z >> 11) & 31)] >> k;
  endfunction

  function automatic void model_accept(input int x, input bit lst, input bit known,
                                       input logic [15:0] kp);
    int unsigned e [VEC_MAX];
    int unsigned sum;
    int unsigned t;
    longint unsigned q;
    prob_t r;
    if (m_count < VEC_MAX) begin
      m_logit[m_count] = x;
      kn_flag[m_count] = known;
      kn_prob[m_count] = kp;
      if (x > m_rmax) begin
        m_rmax = x;
      end
      m_count++;
    end
    if (lst) begin
      sum = 0;
      for (int i = 0; i < m_count; i++) begin
        t = (m_rmax - m_logit[i]) & 255;
        e[i] = exp_of_distance(t) & 32'hFFFF;
        if (t == 0) begin
          e[i] = 32768;
        end
        sum = (sum + e[i]) & 32'h7FFFFF;
      end
      for (int i = 0; i < m_count; i++) begin
        q = 65535;
        if (sum != 0) begin
          q = e[i];
          q = ((q << 16) + (sum >> 1)) / sum;
          if (q > 65535) begin
            q = 65535;
          end
        end
        r.idx  = 6'(i);
        r.prob = kn_flag[i] ? kn_prob[i] : 16'(q);
        r.last = (i + 1 == m_count);
        exp_q.push_back(r);
      end
      m_count = 0;
      m_rmax  = -128;
    end
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_item(input logic [7:0] lg, input bit lst, input bit known,
                           input logic [15:0] kp);
    int gap;
    if (!no_idle && ($urandom_range(0, 4) == 0)) begin
      gap = $urandom_range(1, 5);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= lg;
    s_axis_tlast  <= lst;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    model_accept(int'($signed(lg)), lst, known, kp);
    n_sent++;
    @(negedge clk);
  endtask

  // Waits until every expected result has come out.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (exp_q.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_cfg(input logic [4:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    m_fix = int'($signed(v));
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int gap;
    forever begin
      @(negedge clk);
      if (!rst && !no_idle && ($urandom_range(0, 5) == 0)) begin
        gap = $urandom_range(1, 5);
        m_axis_tready <= 1'b0;
        repeat (gap) @(negedge clk);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= !rst;
      end
    end
  end

  always @(posedge clk) begin
    prob_t e;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (exp_q.size() == 0) begin
        $error("unexpected transaction: element_index %0d", m_axis_tdata[5:0]);
        errors++;
      end else begin
        e = exp_q.pop_front();
        if (m_axis_tdata[5:0] !== e.idx) begin
          $error("element_index: expected %0d, actual %0d", e.idx, m_axis_tdata[5:0]);
          errors++;
        end
        if (m_axis_tdata[21:6] !== e.prob) begin
          $error("probability: expected %0d, actual %0d", e.prob, m_axis_tdata[21:6]);
          errors++;
        end
        if (m_axis_tlast !== e.last) begin
          $error("last_out: expected %0d, actual %0d", e.last, m_axis_tlast);
          errors++;
        end
      end
    end
  end

  initial begin
    int vlen;
    int base;
    bit spread;
    logic [7:0] lg;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_rows[r]) begin
      send_item(dir_rows[r].logit, dir_rows[r].last, dir_rows[r].known,
                dir_rows[r].known_prob);
    end
    drain();

    // A vector longer than the store; the tail is dropped.
    for (int k = 0; k < 70; k++) begin
      send_item(8'($urandom_range(0, 255)), k == 69, 1'b0, '0);
    end
    drain();

    // Scale extremes, including values outside the usual range.
    foreach (cfg_vals[c]) begin
      write_cfg(cfg_vals[c]);
      for (int k = 0; k < 6; k++) begin
        send_item(8'($urandom_range(0, 255)), k == 5, 1'b0, '0);
      end
      drain();
    end
    write_cfg(5'd4);

    while (n_sent < ITEM_TARGET) begin
      if (n_sent >= ITEM_TARGET - 80) begin
        no_idle = 1'b1;
      end
      if ($urandom_range(0, 5) == 0) begin
        drain();
        write_cfg(5'($urandom_range(0, 31)));
      end
      vlen = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 72) : $urandom_range(1, 16);
      if (vlen > ITEM_TARGET - n_sent) begin
        vlen = ITEM_TARGET - n_sent;
      end
      base   = int'($urandom_range(0, 200)) - 100;
      spread = ($urandom_range(0, 1) == 0);
      for (int k = 0; k < vlen; k++) begin
        if (spread) begin
          lg = 8'($urandom_range(0, 255));
        end else begin
          lg = 8'(base + int'($urandom_range(0, 24)) - 12);
        end
        send_item(lg, k == vlen - 1, 1'b0, '0);
      end
    end
    drain();
    repeat (10) @(negedge clk);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
